>>> rtl/core/emsl_pkg.sv
// Shared constants, codes and types for the extent map sector lookup block.
package emsl_pkg;

    localparam int MAX_EXTENTS = 8;
    localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    localparam int CFG_W       = 4;
    localparam int ENTRY_W     = 3;
    localparam int START_W     = 64;
    localparam int LEN_W       = 32;
    localparam int OFFSET_W    = 64;
    localparam int REQ_W       = 32;
    localparam int PHYS_W      = 64;
    localparam int RUN_W       = 32;

    localparam int IN_BITS     = ENTRY_W + START_W + LEN_W + OFFSET_W + REQ_W;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((PHYS_W + RUN_W + 7) / 8) * 8;

    localparam int ENTRY_LSB   = 0;
    localparam int START_LSB   = ENTRY_LSB + ENTRY_W;
    localparam int LEN_LSB     = START_LSB + START_W;
    localparam int OFFSET_LSB  = LEN_LSB + LEN_W;
    localparam int REQ_LSB     = OFFSET_LSB + OFFSET_W;

    localparam int PHYS_LSB    = 0;
    localparam int RUN_LSB     = PHYS_LSB + PHYS_W;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] addr;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } tbl_wr_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } tbl_entry_t;

endpackage

>>> rtl/core/emsl_table.sv
// Extent table memory: one write port, one read port with registered read data.
module emsl_table (
    input  logic                      aclk,
    input  emsl_pkg::tbl_wr_t         wr,
    input  logic                      rd_en,
    input  logic [emsl_pkg::IDX_W-1:0] rd_addr,
    output emsl_pkg::tbl_entry_t      rd_data
);
    import emsl_pkg::*;

    tbl_entry_t mem [MAX_EXTENTS];
    tbl_entry_t rd_data_reg;

    // Slots beyond the table are dropped.
    always_ff @(posedge aclk) begin
        if (wr.en && (int'(wr.addr) < MAX_EXTENTS)) begin
            mem[wr.addr[IDX_W-1:0]] <= '{start: wr.start, length: wr.length};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/extent_map_sector_lookup.sv
// Top level of the extent map sector lookup block: control walk and result register.
//
//   channel   direction  handshake           payload
//   s_        in         s_tvalid/s_tready   tuser: operation; tdata: write and lookup fields
//   m_        out        m_tvalid/m_tready   tuser: found; tdata: physical_sector, run_length
//   cfg_      in         cfg_we              cfg_wdata: active_extents
//
// A write item produces no result. A lookup item walks n table entries, where n is
// at least one and at most MAX_EXTENTS: the extent memory delivers one entry per cycle
// while the walk is not held, and each entry gets one compare and subtract on the
// running offset. The result enters the output register with the last entry visited;
// a stalled output holds the walk on that entry until the register frees up.
// Reset (aresetn low at a clock edge) clears control state and active_extents; the
// table contents stay undefined until written.
module extent_map_sector_lookup (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: active_extents.
    input  logic                           cfg_we,
    input  logic [emsl_pkg::CFG_W-1:0]     cfg_wdata,
    // Input channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata from bit 0: entry_index, extent_start, extent_length, sector_offset,
    // requested_count, zero padding.
    input  logic [emsl_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: operation.
    input  logic                           s_tuser,
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata from bit 0: physical_sector, run_length.
    output logic [emsl_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: found.
    output logic                           m_tuser
);
    import emsl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     active_reg;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    logic [REQ_W-1:0]     want_reg, want_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_found_reg, m_found_next;
    logic [PHYS_W-1:0]    m_phys_reg, m_phys_next;
    logic [RUN_W-1:0]     m_run_reg, m_run_next;

    tbl_wr_t              tbl_wr;
    logic                 tbl_rd_en;
    logic [IDX_W-1:0]     tbl_rd_addr;
    tbl_entry_t           tbl_rd;

    logic                 in_acc;
    logic                 out_free;
    logic                 hit;
    logic                 last;
    logic [LEN_W-1:0]     avail;
    logic [REQ_W-1:0]     in_req;

    emsl_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_req   = s_tdata[REQ_LSB +: REQ_W];

    // Writes land in the memory at the accepting edge. The earliest read of that entry
    // is issued in the following cycle, so no forwarding path is needed.
    assign tbl_wr.en     = in_acc && (s_tuser == OP_WRITE);
    assign tbl_wr.addr   = s_tdata[ENTRY_LSB +: ENTRY_W];
    assign tbl_wr.start  = s_tdata[START_LSB +: START_W];
    assign tbl_wr.length = s_tdata[LEN_LSB +: LEN_W];

    // The entry in tbl_rd is entry idx_reg. It holds the offset when the remaining
    // offset falls strictly below its length; a zero-length entry never does.
    assign hit   = (limit_reg != '0) && (offset_reg < {{(OFFSET_W-LEN_W){1'b0}}, tbl_rd.length});
    assign last  = (limit_reg == '0) || ((CNT_W'(idx_reg) + CNT_W'(1)) == limit_reg);
    // On a hit the offset is below a 32-bit length, so its low bits are the whole value.
    assign avail = tbl_rd.length - offset_reg[LEN_W-1:0];

    always_comb begin
        state_next    = state_reg;
        offset_next   = offset_reg;
        want_next     = want_reg;
        limit_next    = limit_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_found_next  = m_found_reg;
        m_phys_next   = m_phys_reg;
        m_run_next    = m_run_reg;
        tbl_rd_en     = 1'b0;
        tbl_rd_addr   = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (s_tuser == OP_LOOKUP)) begin
                    offset_next = s_tdata[OFFSET_LSB +: OFFSET_W];
                    want_next   = (in_req == '0) ? REQ_W'(1) : in_req;
                    if (int'(active_reg) > MAX_EXTENTS) begin
                        limit_next = CNT_W'(MAX_EXTENTS);
                    end else begin
                        limit_next = CNT_W'(active_reg);
                    end
                    idx_next    = '0;
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = '0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (hit || last) begin
                    // Stay on this entry until the output register can take the result.
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_found_next  = hit;
                        m_phys_next   = hit ? (tbl_rd.start + offset_reg) : '0;
                        m_run_next    = hit ? ((want_reg < avail) ? want_reg : avail) : '0;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    offset_next = offset_reg - {{(OFFSET_W-LEN_W){1'b0}}, tbl_rd.length};
                    idx_next    = idx_reg + IDX_W'(1);
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = idx_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            active_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                active_reg <= cfg_wdata;
            end
        end
        offset_reg  <= offset_next;
        want_reg    <= want_next;
        limit_reg   <= limit_next;
        idx_reg     <= idx_next;
        m_found_reg <= m_found_next;
        m_phys_reg  <= m_phys_next;
        m_run_reg   <= m_run_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    always_comb begin
        m_tdata                          = '0;
        m_tdata[PHYS_LSB +: PHYS_W]      = m_phys_reg;
        m_tdata[RUN_LSB +: RUN_W]        = m_run_reg;
    end

    // A not-found result carries zero in both payload fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero payload");

    // A found result always offers at least one sector.
    a_hit_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[RUN_LSB +: RUN_W] != '0)
        else $error("found result with zero run length");

    // With a nonzero active limit, the walk never visits an entry at or past that limit.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK && limit_reg != '0 |-> CNT_W'(idx_reg) < limit_reg)
        else $error("walk index beyond active extents");

    // An accepted lookup starts the walk in the next cycle.
    a_lookup_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_LOOKUP |=> state_reg == ST_WALK)
        else $error("lookup accepted without starting a walk");

endmodule
